FILE: rtl/core/rank_labels_by_frequency_core_defines.svh
// Assertion macros for the frequency rank relabel core
`ifndef RANK_LABELS_BY_FREQUENCY_CORE_DEFINES_SVH
`define RANK_LABELS_BY_FREQUENCY_CORE_DEFINES_SVH

// Condition implies consequence in the same cycle
`define RLF_ASSERT_NOW(name, clk, rstn, cond, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle
`define RLF_ASSERT_NEXT(name, clk, rstn, cond, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rlf_pkg.sv
// Shared types and constants for the frequency rank relabel core
`default_nettype none
package rlf_pkg;
    localparam int LABEL_SPACE = 1024;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 17;
    localparam int LBL_W       = 11;
    localparam logic [CNT_W-1:0] SAT_LIMIT = 17'd65536;

    localparam logic [1:0] REQ_COUNT = 2'd0;
    localparam logic [1:0] REQ_MAP   = 2'd1;
    localparam logic [1:0] REQ_SIZE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LBL  = 2'd1;
    localparam logic [1:0] ST_BAD_RANK = 2'd2;

    localparam logic signed [LBL_W-1:0] LBL_NONE = -11'sd1;

    // one sort entry: old label and its member count
    typedef struct packed {
        logic [IDX_W-1:0] label;
        logic [CNT_W-1:0] cnt;
    } work_entry_t;
endpackage
`default_nettype wire

FILE: rtl/core/rank_labels_by_frequency_core.sv
// Top level of the frequency rank relabel core
//
//  channel | ports                                              | direction
//  s_      | req_type, label, rank, last                        | in
//  m_      | new_label, community_size, community_count, status | out
//
// Map and size words pass S_LOOKUP and S_RESP; a count word that is not last passes
// S_CNT_RD and S_CNT_WR and gives no response. The last count word runs the ranking: a
// histogram scan, a merge sort of n labels on one compare unit in ceil(log2 n) passes,
// and a write-back of ids and sizes.
// A count word after ranking first sweeps the histogram to zero, as reset does before
// s_ready rises; s_ready is high only when idle, so a stalled result blocks.
`default_nettype none
`include "rank_labels_by_frequency_core_defines.svh"
module rank_labels_by_frequency_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_req_type,
    input  wire logic signed [rlf_pkg::LBL_W-1:0]  s_label,
    input  wire logic [rlf_pkg::IDX_W-1:0]         s_rank,
    input  wire logic                              s_last,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [rlf_pkg::LBL_W-1:0]       m_new_label,
    output logic [rlf_pkg::CNT_W-1:0]              m_community_size,
    output logic [rlf_pkg::LBL_W-1:0]              m_community_count,
    output logic [1:0]                             m_status
);
    import rlf_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_CNT_RD  = 4'd2;
    localparam logic [3:0] S_CNT_WR  = 4'd3;
    localparam logic [3:0] S_GTH_RD  = 4'd4;
    localparam logic [3:0] S_GTH_CHK = 4'd5;
    localparam logic [3:0] S_PASS    = 4'd6;
    localparam logic [3:0] S_SEG     = 4'd7;
    localparam logic [3:0] S_MWAIT   = 4'd8;
    localparam logic [3:0] S_MCMP    = 4'd9;
    localparam logic [3:0] S_WB_RD   = 4'd10;
    localparam logic [3:0] S_WB_WR   = 4'd11;
    localparam logic [3:0] S_LOOKUP  = 4'd12;
    localparam logic [3:0] S_RESP    = 4'd13;

    localparam logic [LBL_W-1:0] LAST_IDX = LBL_W'(LABEL_SPACE - 1);

    logic [3:0]        state_reg, state_next;
    logic              boot_reg, boot_next;
    logic              ranked_reg, ranked_next;
    logic [LBL_W-1:0]  distinct_reg, distinct_next;
    logic [1:0]        req_reg, req_next;
    logic signed [LBL_W-1:0] lbl_reg, lbl_next;
    logic [IDX_W-1:0]  rank_reg, rank_next;
    logic              last_reg, last_next;
    logic [LBL_W-1:0]  g_reg, g_next;
    logic [LBL_W-1:0]  k_reg, k_next;
    logic [LBL_W-1:0]  p_reg, p_next;
    logic [LBL_W-1:0]  q_reg, q_next;
    logic [LBL_W-1:0]  i_reg, i_next;
    logic [LBL_W-1:0]  w_reg, w_next;
    logic [LBL_W-1:0]  mid_reg, mid_next;
    logic [LBL_W-1:0]  hi_reg, hi_next;
    logic              src_reg, src_next;
    logic              mv_reg, mv_next;
    logic signed [LBL_W-1:0] onl_reg, onl_next;
    logic [CNT_W-1:0]  osz_reg, osz_next;
    logic [LBL_W-1:0]  ocnt_reg, ocnt_next;
    logic [1:0]        ost_reg, ost_next;

    // histogram and result stores
    logic [CNT_W-1:0] hist_mem [LABEL_SPACE];
    logic [IDX_W-1:0] id_mem   [LABEL_SPACE];
    logic [CNT_W-1:0] sz_mem   [LABEL_SPACE];
    logic [CNT_W-1:0] hist_q, sz_q;
    logic [IDX_W-1:0] id_q;
    logic             hist_we, res_we;
    logic [IDX_W-1:0] hist_raddr, hist_waddr;
    logic [CNT_W-1:0] hist_wdata;

    // sort work memories
    logic        wa_we, wb_we, merge_we;
    logic [IDX_W-1:0] wk_addr;
    work_entry_t wk_data;
    work_entry_t a0, a1, b0, b1, dp, dq;
    logic        pa, qa, take_q;
    logic [LBL_W-1:0] sum_mid, sum_hi, cnt_now;

    rlf_work_ram u_ram_a (
        .aclk(aclk), .we(wa_we), .waddr(wk_addr), .wdata(wk_data),
        .raddr0(p_reg[IDX_W-1:0]), .raddr1(q_reg[IDX_W-1:0]),
        .rdata0(a0), .rdata1(a1)
    );
    rlf_work_ram u_ram_b (
        .aclk(aclk), .we(wb_we), .waddr(wk_addr), .wdata(wk_data),
        .raddr0(p_reg[IDX_W-1:0]), .raddr1(q_reg[IDX_W-1:0]),
        .rdata0(b0), .rdata1(b1)
    );

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_q <= hist_mem[hist_raddr];
    end

    always_ff @(posedge aclk) begin
        if (res_we) begin
            id_mem[dp.label]            <= p_reg[IDX_W-1:0];
            sz_mem[p_reg[IDX_W-1:0]]    <= dp.cnt;
        end
        id_q <= id_mem[lbl_reg[IDX_W-1:0]];
        sz_q <= sz_mem[rank_reg];
    end

    // merge heads from the current source memory
    assign dp = src_reg ? b0 : a0;
    assign dq = src_reg ? b1 : a1;
    assign pa = (p_reg < mid_reg);
    assign qa = (q_reg < hi_reg);
    assign take_q = qa && (!pa || (dq.cnt > dp.cnt) ||
                    ((dq.cnt == dp.cnt) && (dq.label < dp.label)));
    assign sum_mid = i_reg + w_reg;
    assign sum_hi  = i_reg + (w_reg << 1);
    assign cnt_now = ranked_reg ? distinct_reg : '0;

    assign wa_we = merge_we ? src_reg : (state_reg == S_GTH_CHK && hist_q != '0);
    assign wb_we = merge_we && !src_reg;

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = mv_reg;
    assign m_new_label       = onl_reg;
    assign m_community_size  = osz_reg;
    assign m_community_count = ocnt_reg;
    assign m_status          = ost_reg;

    // sequencer
    always_comb begin
        state_next = state_reg; boot_next = boot_reg; ranked_next = ranked_reg;
        distinct_next = distinct_reg; req_next = req_reg; lbl_next = lbl_reg;
        rank_next = rank_reg; last_next = last_reg; g_next = g_reg; k_next = k_reg;
        p_next = p_reg; q_next = q_reg; i_next = i_reg; w_next = w_reg;
        mid_next = mid_reg; hi_next = hi_reg; src_next = src_reg;
        onl_next = onl_reg; osz_next = osz_reg; ocnt_next = ocnt_reg; ost_next = ost_reg;
        mv_next = mv_reg && !m_ready;
        hist_we = 1'b0; hist_waddr = lbl_reg[IDX_W-1:0]; hist_wdata = '0;
        hist_raddr = lbl_reg[IDX_W-1:0];
        res_we = 1'b0; merge_we = 1'b0;
        wk_addr = k_reg[IDX_W-1:0];
        wk_data = '{label: g_reg[IDX_W-1:0], cnt: hist_q};
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_req_type; lbl_next = s_label;
                    rank_next = s_rank; last_next = s_last; g_next = '0;
                    priority case (s_req_type)
                        REQ_COUNT: state_next = ranked_reg ? S_CLEAR : S_CNT_RD;
                        REQ_MAP, REQ_SIZE: state_next = S_LOOKUP;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                // sweep the histogram to zero
                hist_we = 1'b1; hist_waddr = g_reg[IDX_W-1:0];
                g_next = g_reg + 1'b1;
                if (g_reg == LAST_IDX) begin
                    ranked_next = 1'b0; distinct_next = '0; boot_next = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_CNT_RD;
                end
            end
            S_CNT_RD: state_next = S_CNT_WR;
            S_CNT_WR: begin
                // bump the bin, saturating; negative labels are unassigned
                if (!lbl_reg[LBL_W-1]) begin
                    if (hist_q == '0) distinct_next = distinct_reg + 1'b1;
                    if (hist_q < SAT_LIMIT) begin
                        hist_we = 1'b1; hist_wdata = hist_q + 1'b1;
                    end
                end
                g_next = '0; k_next = '0;
                state_next = last_reg ? S_GTH_RD : S_IDLE;
            end
            S_GTH_RD: begin
                hist_raddr = g_reg[IDX_W-1:0];
                state_next = S_GTH_CHK;
            end
            S_GTH_CHK: begin
                // collect every counted label into work memory A
                if (hist_q != '0) k_next = k_reg + 1'b1;
                g_next = g_reg + 1'b1;
                if (g_reg == LAST_IDX) begin
                    w_next = LBL_W'(1); src_next = 1'b0; state_next = S_PASS;
                end else begin
                    state_next = S_GTH_RD;
                end
            end
            S_PASS: begin
                i_next = '0; p_next = '0;
                if (w_reg >= distinct_reg) begin
                    if (distinct_reg == '0) begin
                        ranked_next = 1'b1; state_next = S_RESP;
                    end else begin
                        state_next = S_WB_RD;
                    end
                end else begin
                    state_next = S_SEG;
                end
            end
            S_SEG: begin
                mid_next = (sum_mid < distinct_reg) ? sum_mid : distinct_reg;
                hi_next  = (sum_hi < distinct_reg) ? sum_hi : distinct_reg;
                p_next = i_reg;
                q_next = (sum_mid < distinct_reg) ? sum_mid : distinct_reg;
                k_next = i_reg;
                state_next = S_MWAIT;
            end
            S_MWAIT: state_next = S_MCMP;
            S_MCMP: begin
                if (!pa && !qa) begin
                    i_next = hi_reg;
                    if (hi_reg == distinct_reg) begin
                        w_next = w_reg << 1; src_next = !src_reg; state_next = S_PASS;
                    end else begin
                        state_next = S_SEG;
                    end
                end else begin
                    // move the winning head to the destination memory
                    merge_we = 1'b1;
                    wk_data = take_q ? dq : dp;
                    k_next = k_reg + 1'b1;
                    if (take_q) q_next = q_reg + 1'b1;
                    else p_next = p_reg + 1'b1;
                    state_next = S_MWAIT;
                end
            end
            S_WB_RD: state_next = S_WB_WR;
            S_WB_WR: begin
                // store new id and size for rank p
                res_we = 1'b1;
                p_next = p_reg + 1'b1;
                if (p_reg + 1'b1 == distinct_reg) begin
                    ranked_next = 1'b1; state_next = S_RESP;
                end else begin
                    state_next = S_WB_RD;
                end
            end
            S_LOOKUP: state_next = S_RESP;
            S_RESP: begin
                // load the output register once it is free
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1; state_next = S_IDLE;
                    onl_next = LBL_NONE; osz_next = '0; ost_next = ST_OK;
                    ocnt_next = cnt_now;
                    priority if (req_reg == REQ_COUNT) begin
                        ocnt_next = distinct_reg;
                    end else if (req_reg == REQ_MAP) begin
                        if (!lbl_reg[LBL_W-1]) begin
                            if (!ranked_reg || hist_q == '0) ost_next = ST_BAD_LBL;
                            else onl_next = signed'({1'b0, id_q});
                        end
                    end else begin
                        if (!ranked_reg || {1'b0, rank_reg} >= distinct_reg) begin
                            ost_next = ST_BAD_RANK;
                        end else begin
                            osz_next = sz_q;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR; boot_reg <= 1'b1; ranked_reg <= 1'b0;
            distinct_reg <= '0; g_reg <= '0; mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next; boot_reg <= boot_next; ranked_reg <= ranked_next;
            distinct_reg <= distinct_next; g_reg <= g_next; mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next; lbl_reg <= lbl_next; rank_reg <= rank_next;
        last_reg <= last_next; k_reg <= k_next; p_reg <= p_next; q_reg <= q_next;
        i_reg <= i_next; w_reg <= w_next; mid_reg <= mid_next; hi_reg <= hi_next;
        src_reg <= src_next; onl_reg <= onl_next; osz_reg <= osz_next;
        ocnt_reg <= ocnt_next; ost_reg <= ost_next;
    end

    `RLF_ASSERT_NOW(a_distinct_bound, aclk, aresetn, 1'b1, distinct_reg <= LBL_W'(LABEL_SPACE), "distinct count beyond label space")
    `RLF_ASSERT_NOW(a_merge_ptrs, aclk, aresetn, state_reg == S_MCMP, p_reg <= mid_reg && q_reg <= hi_reg, "merge pointer past its run")
    `RLF_ASSERT_NEXT(a_rank_done, aclk, aresetn, state_reg == S_RESP && ranked_reg && req_reg == REQ_COUNT, distinct_reg == $past(distinct_reg), "count changed while reporting ranking")
endmodule
`default_nettype wire

FILE: rtl/core/rlf_work_ram.sv
// Sort work memory: one write port, two registered read ports
`default_nettype none
module rlf_work_ram (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [rlf_pkg::IDX_W-1:0]  waddr,
    input  wire rlf_pkg::work_entry_t       wdata,
    input  wire logic [rlf_pkg::IDX_W-1:0]  raddr0,
    input  wire logic [rlf_pkg::IDX_W-1:0]  raddr1,
    output rlf_pkg::work_entry_t            rdata0,
    output rlf_pkg::work_entry_t            rdata1
);
    import rlf_pkg::*;

    work_entry_t mem [LABEL_SPACE];

    // write one word, read two
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end
endmodule
`default_nettype wire
